// ===== src/ptpol_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpol_pkg
// constants shared by the point pair to polar datapath: cordic angle table,
// gain compensation and output field widths
// ----------------------------------------------------------------------------
package ptpol_pkg;

    localparam int GUARD        = 24;
    localparam int ATAN_ENTRIES = 24;
    localparam int DIST_WIDTH   = 18;
    localparam int DIR_WIDTH    = 16;
    localparam int MUL_WIDTH    = 27;
    localparam int ANGLE_WIDTH  = 32;

    localparam logic [ANGLE_WIDTH-1:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [ANGLE_WIDTH-1:0] DIR_ROUND  = 32'h0000_8000;
    localparam logic [31:0]            KINV       = 32'h9B74_EDA8;
    localparam logic [DIST_WIDTH-1:0]  DIST_MAX   = '1;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn
    localparam logic [ANGLE_WIDTH-1:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

// ===== src/point_pair_to_polar.sv =====
// ----------------------------------------------------------------------------
// point_pair_to_polar
// distance and direction between two q8.8 points through an unrolled cordic
// vectoring pipeline with one register per micro-rotation
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the output is not stalled, set by one cordic rotation per pipeline stage
// every stage has its own valid bit and advances into an empty or moving slot,
// so bubbles close up while the output is stalled
// reset clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
module point_pair_to_polar #(
    parameter  int COORD_WIDTH   = 16,
    parameter  int CORDIC_STAGES = 16,
    localparam int S_DATA_WIDTH  = ((4 * COORD_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_WIDTH  = ((ptpol_pkg::DIST_WIDTH + ptpol_pkg::DIR_WIDTH + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // start_x, start_y, end_x, end_y
    input  logic [S_DATA_WIDTH-1:0] s_tdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // distance, direction
    output logic [M_DATA_WIDTH-1:0] m_tdata,
    // degenerate
    output logic                    m_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready
);
    import ptpol_pkg::*;

    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int DW         = COORD_WIDTH + GUARD + 3;
    localparam int XSH_WIDTH  = DW - (GUARD - 8);
    localparam int XE_WIDTH   = (XSH_WIDTH > MUL_WIDTH) ? XSH_WIDTH : MUL_WIDTH;
    localparam int PROD_WIDTH = MUL_WIDTH + 32;
    localparam int N          = CORDIC_STAGES;

    // input fields
    logic signed [COORD_WIDTH-1:0] start_x, start_y, end_x, end_y;

    assign start_x = s_tdata[COORD_WIDTH-1:0];
    assign start_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign end_x   = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign end_y   = s_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];

    // difference stage
    logic                         d_valid_reg;
    logic signed [DIFF_WIDTH-1:0] d_dx_reg, d_dy_reg;
    logic                         d_deg_reg;
    logic                         d_ready;
    logic signed [DIFF_WIDTH-1:0] d_dx_next, d_dy_next;

    // cordic stages, index 0 is the pre-rotation
    logic                         c_valid_reg [0:N];
    logic signed [DW-1:0]         c_x_reg     [0:N];
    logic signed [DW-1:0]         c_y_reg     [0:N];
    logic [ANGLE_WIDTH-1:0]       c_z_reg     [0:N];
    logic                         c_deg_reg   [0:N];
    logic                         c_ready     [0:N];

    // product stage
    logic                         p_valid_reg;
    logic [PROD_WIDTH-1:0]        p_prod_reg;
    logic [DIR_WIDTH-1:0]         p_dir_reg;
    logic                         p_deg_reg;
    logic                         p_ready;

    // output stage
    logic                         o_valid_reg;
    logic [DIST_WIDTH-1:0]        o_dist_reg;
    logic [DIR_WIDTH-1:0]         o_dir_reg;
    logic                         o_deg_reg;
    logic                         o_ready;

    // ready chain
    assign o_ready  = !o_valid_reg || m_tready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign c_ready[N] = !c_valid_reg[N] || p_ready;
    for (genvar k = 0; k < N; k++) begin : g_rdy
        assign c_ready[k] = !c_valid_reg[k] || c_ready[k+1];
    end
    assign d_ready  = !d_valid_reg || c_ready[0];
    assign s_tready = d_ready;

    // difference
    assign d_dx_next = DIFF_WIDTH'(end_x) - DIFF_WIDTH'(start_x);
    assign d_dy_next = DIFF_WIDTH'(end_y) - DIFF_WIDTH'(start_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_ready) begin
            d_valid_reg <= s_tvalid;
        end
        if (d_ready && s_tvalid) begin
            d_dx_reg  <= d_dx_next;
            d_dy_reg  <= d_dy_next;
            d_deg_reg <= (d_dx_next == '0) && (d_dy_next == '0);
        end
    end

    // pre-rotation into the right half plane
    logic signed [DW-1:0] pre_x, pre_y;
    logic                 pre_neg;

    assign pre_neg = d_dx_reg[DIFF_WIDTH-1];
    assign pre_x   = pre_neg ? -(DW'(d_dx_reg) <<< GUARD) : (DW'(d_dx_reg) <<< GUARD);
    assign pre_y   = pre_neg ? -(DW'(d_dy_reg) <<< GUARD) : (DW'(d_dy_reg) <<< GUARD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg[0] <= 1'b0;
        end else if (c_ready[0]) begin
            c_valid_reg[0] <= d_valid_reg;
        end
        if (c_ready[0] && d_valid_reg) begin
            c_x_reg[0]   <= pre_x;
            c_y_reg[0]   <= pre_y;
            c_z_reg[0]   <= pre_neg ? HALF_TURN : '0;
            c_deg_reg[0] <= d_deg_reg;
        end
    end

    // micro-rotations
    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [DW-1:0]   x_sh, y_sh, c_x_next, c_y_next;
        logic [ANGLE_WIDTH-1:0] c_z_next;
        logic                   y_neg;

        assign y_neg = c_y_reg[i][DW-1];
        assign x_sh  = c_x_reg[i] >>> i;
        assign y_sh  = c_y_reg[i] >>> i;

        always_comb begin
            if (!y_neg) begin
                c_x_next = c_x_reg[i] + y_sh;
                c_y_next = c_y_reg[i] - x_sh;
                c_z_next = c_z_reg[i] + ATAN_TURNS[i];
            end else begin
                c_x_next = c_x_reg[i] - y_sh;
                c_y_next = c_y_reg[i] + x_sh;
                c_z_next = c_z_reg[i] - ATAN_TURNS[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                c_valid_reg[i+1] <= 1'b0;
            end else if (c_ready[i+1]) begin
                c_valid_reg[i+1] <= c_valid_reg[i];
            end
            if (c_ready[i+1] && c_valid_reg[i]) begin
                c_x_reg[i+1]   <= c_x_next;
                c_y_reg[i+1]   <= c_y_next;
                c_z_reg[i+1]   <= c_z_next;
                c_deg_reg[i+1] <= c_deg_reg[i];
            end
        end
    end

    // gain compensation multiply, operand clamped where the result saturates anyway
    logic [XSH_WIDTH-1:0]   x_sh_mag;
    logic [XE_WIDTH-1:0]    x_ext;
    logic [MUL_WIDTH-1:0]   mul_in;
    logic [PROD_WIDTH-1:0]  p_prod_next;
    logic [ANGLE_WIDTH-1:0] z_round;

    assign x_sh_mag    = c_x_reg[N][DW-1] ? '0 : c_x_reg[N][DW-1:GUARD-8];
    assign x_ext       = XE_WIDTH'(x_sh_mag);
    assign mul_in      = (|(x_ext >> MUL_WIDTH)) ? '1 : x_ext[MUL_WIDTH-1:0];
    assign p_prod_next = PROD_WIDTH'(mul_in) * PROD_WIDTH'(KINV);
    assign z_round     = c_z_reg[N] + DIR_ROUND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_ready) begin
            p_valid_reg <= c_valid_reg[N];
        end
        if (p_ready && c_valid_reg[N]) begin
            p_prod_reg <= p_prod_next;
            p_dir_reg  <= z_round[ANGLE_WIDTH-1:ANGLE_WIDTH-DIR_WIDTH];
            p_deg_reg  <= c_deg_reg[N];
        end
    end

    // rounding, saturation and coincident points
    logic [PROD_WIDTH:0]          rnd_sum;
    logic [PROD_WIDTH-40:0]       dist_wide;
    logic [DIST_WIDTH-1:0]        o_dist_next;

    assign rnd_sum     = (PROD_WIDTH + 1)'(p_prod_reg) + ((PROD_WIDTH + 1)'(1) << 39);
    assign dist_wide   = rnd_sum[PROD_WIDTH:40];
    assign o_dist_next = (|(dist_wide >> DIST_WIDTH)) ? DIST_MAX
                                                      : dist_wide[DIST_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_ready) begin
            o_valid_reg <= p_valid_reg;
        end
        if (o_ready && p_valid_reg) begin
            o_dist_reg <= p_deg_reg ? '0 : o_dist_next;
            o_dir_reg  <= p_deg_reg ? '0 : p_dir_reg;
            o_deg_reg  <= p_deg_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_deg_reg;
    assign m_tdata  = M_DATA_WIDTH'({o_dir_reg, o_dist_reg});

endmodule
